>>> hw/rtl/cbw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbw_pkg: shared types and constants of the barrier watchdog
// Operation, error, run state, register and flag codes and the scan request and response structs.
// ----------------------------------------------------------------------------
package cbw_pkg;

	localparam int unsigned RANKS_DEF = 16;

	localparam logic [3:0] OP_AUTH     = 4'd0;
	localparam logic [3:0] OP_LOCAL    = 4'd1;
	localparam logic [3:0] OP_INPUT    = 4'd2;
	localparam logic [3:0] OP_START    = 4'd3;
	localparam logic [3:0] OP_PROGRESS = 4'd4;
	localparam logic [3:0] OP_COMPLETE = 4'd5;
	localparam logic [3:0] OP_POLL     = 4'd6;
	localparam logic [3:0] OP_CANCEL   = 4'd7;
	localparam logic [3:0] OP_FAIL     = 4'd8;

	localparam logic [3:0] ERR_NONE       = 4'd0;
	localparam logic [3:0] ERR_TERMINAL   = 4'd1;
	localparam logic [3:0] ERR_UNKNOWN    = 4'd2;
	localparam logic [3:0] ERR_EPOCH      = 4'd3;
	localparam logic [3:0] ERR_DIGEST     = 4'd4;
	localparam logic [3:0] ERR_DUP_AUTH   = 4'd5;
	localparam logic [3:0] ERR_UNAUTH     = 4'd6;
	localparam logic [3:0] ERR_DUP_LOCAL  = 4'd7;
	localparam logic [3:0] ERR_NOT_LOCAL  = 4'd8;
	localparam logic [3:0] ERR_INPUT_SEQ  = 4'd9;
	localparam logic [3:0] ERR_DUP_START  = 4'd10;
	localparam logic [3:0] ERR_NOT_READY  = 4'd11;
	localparam logic [3:0] ERR_NOT_RUN    = 4'd12;
	localparam logic [3:0] ERR_DEADLINE   = 4'd13;
	localparam logic [3:0] ERR_PROG_SEQ   = 4'd14;

	localparam logic [2:0] ST_PENDING   = 3'd0;
	localparam logic [2:0] ST_RUNNING   = 3'd1;
	localparam logic [2:0] ST_COMPLETED = 3'd2;
	localparam logic [2:0] ST_FAILED    = 3'd3;
	localparam logic [2:0] ST_CANCELLED = 3'd4;
	localparam logic [2:0] ST_STALLED   = 3'd5;
	localparam logic [2:0] ST_HARD      = 3'd6;

	localparam logic [2:0] REG_EPOCH  = 3'd0;
	localparam logic [2:0] REG_DIGEST = 3'd1;
	localparam logic [2:0] REG_RANKS  = 3'd2;
	localparam logic [2:0] REG_NOPROG = 3'd3;
	localparam logic [2:0] REG_HARD   = 3'd4;

	localparam logic [3:0] F_AUTH  = 4'b0001;
	localparam logic [3:0] F_LOCAL = 4'b0010;
	localparam logic [3:0] F_INPUT = 4'b0100;
	localparam logic [3:0] F_DONE  = 4'b1000;

	// Request from the sequencer to the scan unit and its answer.
	typedef struct packed {
		logic       start;
		logic [3:0] mask;
	} scan_req_t;

	typedef struct packed {
		logic done;
		logic all_set;
	} scan_rsp_t;

endpackage

>>> hw/rtl/cbw_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbw_scan: rank flag scanner
// Walks the known ranks one per cycle and reports whether all carry a mask.
// ----------------------------------------------------------------------------
module cbw_scan import cbw_pkg::*; #(
	parameter int unsigned RANKS = RANKS_DEF,
	parameter int unsigned IW = (RANKS > 1) ? $clog2(RANKS) : 1,
	parameter int unsigned CW = $clog2(RANKS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  scan_req_t           req,
	input  logic [CW-1:0]       known,
	input  logic [RANKS*4-1:0]  flags,
	output scan_rsp_t           rsp
);

	logic          busy_q;
	logic [CW-1:0] idx_q;
	logic          ok_q;
	logic [3:0]    mask_q;
	logic [3:0]    cur;

	assign cur = flags[idx_q[IW-1:0]*4 +: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			ok_q   <= 1'b0;
			mask_q <= '0;
			rsp    <= '0;
		end else begin
			rsp.done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				ok_q   <= 1'b1;
				mask_q <= req.mask;
			end else if (busy_q) begin
				if (idx_q >= known) begin
					busy_q      <= 1'b0;
					rsp.done    <= 1'b1;
					rsp.all_set <= ok_q;
				end else begin
					if ((cur & mask_q) != mask_q) ok_q <= 1'b0;
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

endmodule

>>> hw/rtl/collective_barrier_watchdog.sv
`timescale 1ns / 1ps
// Each accepted word passes the watchdog compare (S_WD), evaluation (S_EVAL) and
// result (S_FIN) states; the stall pass is skipped when the hard deadline trips, and
// a flag scan (input ready, start, complete) adds S_KICK and S_SCAN. One event at a
// time: a new word is taken only when idle and the previous result has been taken.
// Reset: arst_n clears rank flags, sequence numbers, run state and times and
// loads the register defaults; the block is ready the cycle after release.
// ----------------------------------------------------------------------------
// collective_barrier_watchdog: group barrier coordinator with watchdogs
// Sequencer over per-rank state, a shared 33-bit time compare and a scanner.
// ----------------------------------------------------------------------------
module collective_barrier_watchdog import cbw_pkg::*; #(
	parameter int unsigned RANKS = RANKS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// op[3:0], rank_index[7:4], event_epoch[39:8], offered_digest[103:40],
	// sequence_req[135:104], now_ms[167:136]
	input  logic [167:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// accepted[0], error_code[4:1], run_state[7:5], terminal_time[39:8]
	output logic [39:0]  m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	localparam int unsigned IW = (RANKS > 1) ? $clog2(RANKS) : 1;
	localparam int unsigned CW = $clog2(RANKS + 1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_WD    = 7'b0000010,
		S_EVAL  = 7'b0000100,
		S_KICK  = 7'b0001000,
		S_SCAN  = 7'b0010000,
		S_FIN   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t st_q;

	logic [31:0] epoch_q, noprog_q, hard_q;
	logic [63:0] digest_q;
	logic [4:0]  rcount_q;

	logic [RANKS*4-1:0] flags_q;
	logic [31:0] inseq_q [RANKS];
	logic [31:0] prseq_q [RANKS];
	logic [2:0]  gst_q;
	logic        elig_v_q;
	logic [31:0] start_q, end_q, prog_q;
	logic        prog_v_q;

	logic [3:0]  op_q, rank_q;
	logic [31:0] ep_q, seq_q, now_q;
	logic [63:0] dig_q;
	logic [3:0]  err_q;
	logic        ok_q;
	logic        wdtrip_q;
	logic [2:0]  wdst_q;
	logic [1:0]  wdstep_q;
	logic [39:0] out_q;
	logic        outv_q;

	logic [CW-1:0] known;
	scan_req_t     sreq;
	scan_rsp_t     srsp;

	assign known = (rcount_q > 5'(RANKS)) ? CW'(RANKS) : CW'(rcount_q);

	cbw_scan #(.RANKS(RANKS)) u_scan (
		.clk(clk), .arst_n(arst_n), .req(sreq), .known(known),
		.flags(flags_q), .rsp(srsp)
	);

	// Shared time compare: now >= base + limit without wrap.
	logic [31:0] cmp_base, cmp_lim;
	logic        cmp_ge;
	always_comb begin
		cmp_base = (wdstep_q == 2'd0) ? start_q : prog_q;
		cmp_lim  = (wdstep_q == 2'd0) ? hard_q : noprog_q;
		cmp_ge   = {1'b0, now_q} >= ({1'b0, cmp_base} + {1'b0, cmp_lim});
	end

	logic [IW-1:0] r;
	logic [3:0]    rf;
	logic          terminal, rank_bad;
	assign r        = rank_q[IW-1:0];
	assign rf       = flags_q[r*4 +: 4];
	assign terminal = (gst_q >= ST_COMPLETED);
	assign rank_bad = ({1'b0, rank_q} >= 5'(known));

	assign s_tready  = (st_q == S_IDLE) && !outv_q;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = outv_q;
	assign m_tdata   = out_q;

	logic [3:0] rank_err;
	always_comb begin
		if (terminal) rank_err = ERR_TERMINAL;
		else if (rank_bad) rank_err = ERR_UNKNOWN;
		else if (ep_q != epoch_q) rank_err = ERR_EPOCH;
		else rank_err = ERR_NONE;
	end

	// The scan starts in S_KICK, in the cycle after the event is judged, so flag updates
	// made by the event are already visible to the scanner.
	always_comb begin
		sreq.start = (st_q == S_KICK);
		sreq.mask  = (op_q == OP_COMPLETE) ? F_DONE : (F_AUTH | F_LOCAL | F_INPUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			epoch_q  <= 32'd1;
			digest_q <= 64'd1;
			rcount_q <= 5'd16;
			noprog_q <= 32'd1000;
			hard_q   <= 32'd10000;
			flags_q  <= '0;
			for (int i = 0; i < RANKS; i++) begin
				inseq_q[i] <= '0;
				prseq_q[i] <= '0;
			end
			gst_q    <= ST_PENDING;
			elig_v_q <= 1'b0;
			start_q  <= '0;
			end_q    <= '0;
			prog_q   <= '0;
			prog_v_q <= 1'b0;
			outv_q   <= 1'b0;
			err_q    <= '0;
			ok_q     <= 1'b0;
			wdtrip_q <= 1'b0;
			wdst_q   <= ST_PENDING;
			wdstep_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_EPOCH:  epoch_q  <= cfg_data[31:0];
					REG_DIGEST: digest_q <= cfg_data;
					REG_RANKS:  rcount_q <= cfg_data[4:0];
					REG_NOPROG: noprog_q <= cfg_data[31:0];
					REG_HARD:   hard_q   <= cfg_data[31:0];
					default: ;
				endcase
			end
			if (outv_q && m_tready) outv_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						{now_q, seq_q, dig_q, ep_q, rank_q, op_q} <= s_tdata;
						wdstep_q <= 2'd0;
						wdtrip_q <= 1'b0;
						st_q     <= S_WD;
					end
				end
				S_WD: begin
					// Two passes of the shared compare: hard deadline, then stall (skipped if the hard one trips).
					if (wdstep_q == 2'd0) begin
						if (cmp_ge) begin
							wdtrip_q <= 1'b1;
							wdst_q   <= ST_HARD;
							st_q     <= S_EVAL;
						end
						wdstep_q <= 2'd1;
					end else begin
						if (prog_v_q && cmp_ge) begin
							wdtrip_q <= 1'b1;
							wdst_q   <= ST_STALLED;
						end
						st_q <= S_EVAL;
					end
					err_q <= ERR_NONE;
					ok_q  <= 1'b0;
				end
				S_EVAL: begin
					st_q <= S_FIN;
					case (op_q) inside
						OP_AUTH: begin
							if (rank_err != ERR_NONE) err_q <= rank_err;
							else if (dig_q != digest_q || dig_q == '0) err_q <= ERR_DIGEST;
							else if (rf[0]) err_q <= ERR_DUP_AUTH;
							else begin
								flags_q[r*4 +: 4] <= rf | F_AUTH;
								ok_q <= 1'b1;
							end
						end
						OP_LOCAL: begin
							if (rank_err != ERR_NONE) err_q <= rank_err;
							else if (!rf[0]) err_q <= ERR_UNAUTH;
							else if (rf[1]) err_q <= ERR_DUP_LOCAL;
							else begin
								flags_q[r*4 +: 4] <= rf | F_LOCAL;
								ok_q <= 1'b1;
							end
						end
						OP_INPUT: begin
							if (rank_err != ERR_NONE) err_q <= rank_err;
							else if (!rf[0] || !rf[1]) err_q <= ERR_NOT_LOCAL;
							else if (seq_q == '0 || rf[2] || seq_q <= inseq_q[r])
								err_q <= ERR_INPUT_SEQ;
							else begin
								flags_q[r*4 +: 4] <= rf | F_INPUT;
								inseq_q[r] <= seq_q;
								ok_q <= 1'b1;
								st_q <= S_KICK;
							end
						end
						OP_START: begin
							if (terminal) err_q <= ERR_TERMINAL;
							else if (gst_q == ST_RUNNING) err_q <= ERR_DUP_START;
							else begin
								ok_q <= 1'b1;
								st_q <= S_KICK;
							end
						end
						OP_PROGRESS, OP_COMPLETE: begin
							if (rank_err != ERR_NONE) err_q <= rank_err;
							else if (gst_q != ST_RUNNING) err_q <= ERR_NOT_RUN;
							else if (wdtrip_q) begin
								err_q <= ERR_DEADLINE;
								gst_q <= wdst_q;
								end_q <= now_q;
							end else if (!rf[0] || !rf[2] || seq_q == '0 || seq_q <= prseq_q[r])
								err_q <= ERR_PROG_SEQ;
							else begin
								prseq_q[r] <= seq_q;
								prog_q   <= now_q;
								prog_v_q <= 1'b1;
								ok_q <= 1'b1;
								if (op_q == OP_COMPLETE) begin
									flags_q[r*4 +: 4] <= rf | F_DONE;
									st_q <= S_KICK;
								end
							end
						end
						OP_POLL: begin
							ok_q <= 1'b1;
							if (gst_q == ST_RUNNING && wdtrip_q) begin
								gst_q <= wdst_q;
								end_q <= now_q;
							end
						end
						OP_CANCEL, OP_FAIL: begin
							if (terminal) err_q <= ERR_TERMINAL;
							else begin
								ok_q  <= 1'b1;
								gst_q <= (op_q == OP_CANCEL) ? ST_CANCELLED : ST_FAILED;
								end_q <= now_q;
							end
						end
						default: ;
					endcase
				end
				S_KICK: begin
					st_q <= S_SCAN;
				end
				S_SCAN: begin
					if (srsp.done) begin
						st_q <= S_FIN;
						if (op_q == OP_INPUT) begin
							if (srsp.all_set) elig_v_q <= 1'b1;
						end else if (op_q == OP_START) begin
							if (!srsp.all_set) begin
								err_q <= ERR_NOT_READY;
								ok_q  <= 1'b0;
							end else begin
								elig_v_q <= 1'b1;
								start_q  <= now_q;
								prog_q   <= now_q;
								prog_v_q <= 1'b1;
								gst_q    <= ST_RUNNING;
							end
						end else if (srsp.all_set) begin
							gst_q <= ST_COMPLETED;
							end_q <= now_q;
						end
					end
				end
				S_FIN: begin
					out_q  <= {(terminal ? end_q : 32'd0), gst_q, err_q, ok_q};
					outv_q <= 1'b1;
					st_q   <= S_OUT;
				end
				S_OUT: begin
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> !s_tready) else $error("accepted word while busy");
	a_ok_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		outv_q |-> !(out_q[0] && out_q[4:1] != ERR_NONE)) else $error("accepted with error");
	a_term_time: assert property (@(posedge clk) disable iff (!arst_n)
		(outv_q && out_q[7:5] < ST_COMPLETED) |-> (out_q[39:8] == 32'd0))
		else $error("terminal time on live group");
`endif

endmodule

>>> bench/tb_collective_barrier_watchdog.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_collective_barrier_watchdog: self-checking bench of the barrier watchdog
// Drives rank events through the stream port and predicts each result word from
// a behavioral copy of the barrier state. Registers are changed between phases.
// ----------------------------------------------------------------------------
module tb_collective_barrier_watchdog import cbw_pkg::*;;

	localparam int NR = 16;

	typedef struct packed {
		logic [31:0] now_ms;
		logic [31:0] seq;
		logic [63:0] digest;
		logic [31:0] epoch;
		logic [3:0]  rank;
		logic [3:0]  op;
	} event_t;

	typedef struct packed {
		logic [31:0] term_time;
		logic [2:0]  state;
		logic [3:0]  err;
		logic        ok;
	} verdict_t;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, m_tready = 0, cfg_valid = 0;
	logic s_tready, m_tvalid, cfg_ready;
	logic [167:0] s_tdata = '0;
	logic [39:0] m_tdata;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	collective_barrier_watchdog dut (.*);

	initial forever #4 clk = ~clk;

	// predictor state
	logic [31:0] r_epoch;
	logic [63:0] r_digest;
	logic [4:0]  r_ranks;
	logic [31:0] r_noprog, r_hard;
	logic [3:0]  flags [NR];
	logic [31:0] in_seq [NR], pr_seq [NR];
	logic [2:0]  gstate;
	logic [32:0] elig_t, prog_t;
	logic [31:0] start_t, end_t;

	verdict_t pending_q [$];
	int mismatches = 0;
	longint cycles = 0;

	function automatic int known();
		return (r_ranks > NR) ? NR : int'(r_ranks);
	endfunction

	function automatic bit term();
		return gstate >= ST_COMPLETED;
	endfunction

	function automatic bit all_set(logic [3:0] m);
		for (int i = 0; i < known(); i++)
			if ((flags[i] & m) != m) return 0;
		return 1;
	endfunction

	task automatic end_run(logic [2:0] st, logic [31:0] now);
		if (!term()) begin
			gstate = st;
			end_t = now;
		end
	endtask

	task automatic watch(logic [31:0] now);
		if (gstate == ST_RUNNING) begin
			if ({32'd0, now} >= {32'd0, start_t} + {32'd0, r_hard})
				end_run(ST_HARD, now);
			else if (prog_t[32] && {32'd0, now} >= {32'd0, prog_t[31:0]} + {32'd0, r_noprog})
				end_run(ST_STALLED, now);
		end
	endtask

	function automatic logic [3:0] front(event_t e);
		if (term()) return ERR_TERMINAL;
		if (int'(e.rank) >= known()) return ERR_UNKNOWN;
		if (e.epoch != r_epoch) return ERR_EPOCH;
		return ERR_NONE;
	endfunction

	task automatic progress(event_t e, output logic [3:0] err);
		err = front(e);
		if (err != ERR_NONE) return;
		if (gstate != ST_RUNNING) begin
			err = ERR_NOT_RUN;
			return;
		end
		watch(e.now_ms);
		if (gstate != ST_RUNNING) begin
			err = ERR_DEADLINE;
			return;
		end
		if (!flags[e.rank][0] || !flags[e.rank][2] || e.seq == 0 || e.seq <= pr_seq[e.rank]) begin
			err = ERR_PROG_SEQ;
			return;
		end
		pr_seq[e.rank] = e.seq;
		prog_t = {1'b1, e.now_ms};
	endtask

	task automatic predict_event(event_t e);
		logic [3:0] err;
		bit ok;
		verdict_t v;
		int r;
		err = ERR_NONE;
		ok = 0;
		r = e.rank;
		case (e.op) inside
			OP_AUTH: begin
				err = front(e);
				if (err == ERR_NONE && (e.digest != r_digest || e.digest == 0)) err = ERR_DIGEST;
				if (err == ERR_NONE && flags[r][0]) err = ERR_DUP_AUTH;
				if (err == ERR_NONE) flags[r] |= F_AUTH;
				ok = err == ERR_NONE;
			end
			OP_LOCAL: begin
				err = front(e);
				if (err == ERR_NONE && !flags[r][0]) err = ERR_UNAUTH;
				if (err == ERR_NONE && flags[r][1]) err = ERR_DUP_LOCAL;
				if (err == ERR_NONE) flags[r] |= F_LOCAL;
				ok = err == ERR_NONE;
			end
			OP_INPUT: begin
				err = front(e);
				if (err == ERR_NONE && (!flags[r][0] || !flags[r][1])) err = ERR_NOT_LOCAL;
				if (err == ERR_NONE && (e.seq == 0 || flags[r][2] || e.seq <= in_seq[r]))
					err = ERR_INPUT_SEQ;
				if (err == ERR_NONE) begin
					flags[r] |= F_INPUT;
					in_seq[r] = e.seq;
					if (all_set(F_AUTH | F_LOCAL | F_INPUT) && !elig_t[32])
						elig_t = {1'b1, e.now_ms};
				end
				ok = err == ERR_NONE;
			end
			OP_START: begin
				if (term()) err = ERR_TERMINAL;
				else if (gstate == ST_RUNNING) err = ERR_DUP_START;
				else if (!all_set(F_AUTH | F_LOCAL | F_INPUT)) err = ERR_NOT_READY;
				else begin
					if (!elig_t[32]) elig_t = {1'b1, e.now_ms};
					start_t = e.now_ms;
					prog_t = {1'b1, e.now_ms};
					gstate = ST_RUNNING;
				end
				ok = err == ERR_NONE;
			end
			OP_PROGRESS: begin
				progress(e, err);
				ok = err == ERR_NONE;
			end
			OP_COMPLETE: begin
				progress(e, err);
				if (err == ERR_NONE) begin
					flags[r] |= F_DONE;
					if (all_set(F_DONE)) begin
						gstate = ST_COMPLETED;
						end_t = e.now_ms;
					end
				end
				ok = err == ERR_NONE;
			end
			OP_POLL: begin
				watch(e.now_ms);
				ok = 1;
			end
			OP_CANCEL, OP_FAIL: begin
				if (term()) err = ERR_TERMINAL;
				else begin
					end_run(e.op == OP_CANCEL ? ST_CANCELLED : ST_FAILED, e.now_ms);
					ok = 1;
				end
			end
			default: ;
		endcase
		v.ok = ok;
		v.err = err;
		v.state = gstate;
		v.term_time = term() ? end_t : 32'd0;
		pending_q.push_back(v);
	endtask

	task automatic clear_model();
		r_epoch = 1;
		r_digest = 1;
		r_ranks = 16;
		r_noprog = 1000;
		r_hard = 10000;
		for (int i = 0; i < NR; i++) begin
			flags[i] = 0;
			in_seq[i] = 0;
			pr_seq[i] = 0;
		end
		gstate = ST_PENDING;
		elig_t = 0;
		prog_t = 0;
		start_t = 0;
		end_t = 0;
	endtask

	// The accepted word stays on the bus until the next call or a drain; the
	// block stays busy after any acceptance until its result has been taken, so it
	// is not taken twice.
	task automatic send_event(event_t e);
		int idle;
		idle = $urandom_range(0, 9);
		if (idle > 0) begin
			s_tvalid <= 0;
			repeat (idle) @(negedge clk);
		end
		s_tdata <= e;
		s_tvalid <= 1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_event(e);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_EPOCH:  r_epoch = val[31:0];
			REG_DIGEST: r_digest = val;
			REG_RANKS:  r_ranks = val[4:0];
			REG_NOPROG: r_noprog = val[31:0];
			REG_HARD:   r_hard = val[31:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic event_t mk(logic [3:0] op, logic [3:0] rank, logic [31:0] seq,
			logic [31:0] now);
		event_t e;
		e.op = op;
		e.rank = rank;
		e.epoch = r_epoch;
		e.digest = r_digest;
		e.seq = seq;
		e.now_ms = now;
		return e;
	endfunction

	function automatic event_t noise();
		event_t e;
		e = mk(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), $urandom, $urandom);
		e.digest = {$urandom, $urandom};
		if ($urandom_range(0, 1)) e.epoch = $urandom;
		if ($urandom_range(0, 1)) e.digest = r_digest;
		if ($urandom_range(0, 3) == 0) e.seq = 0;
		return e;
	endfunction

	task automatic test_directed();
		event_t e;
		write_reg(REG_RANKS, 5'd2);
		e = mk(OP_AUTH, 0, 0, 5); e.digest = 0; send_event(e);
		e = mk(OP_AUTH, 0, 0, 5); e.epoch = 0; send_event(e);
		send_event(mk(OP_AUTH, 15, 0, 5));
		send_event(mk(OP_LOCAL, 0, 0, 5));
		send_event(mk(OP_INPUT, 0, 1, 5));
		send_event(mk(OP_START, 0, 0, 5));
		send_event(mk(OP_PROGRESS, 0, 1, 5));
		send_event(mk(4'd9, 0, 0, 5));
		send_event(mk(4'd15, 15, 0, 5));
		send_event(mk(OP_AUTH, 0, 0, 6));
		send_event(mk(OP_AUTH, 0, 0, 6));
		send_event(mk(OP_LOCAL, 0, 0, 6));
		send_event(mk(OP_LOCAL, 0, 0, 6));
		send_event(mk(OP_INPUT, 0, 0, 6));
		send_event(mk(OP_INPUT, 0, 32'hFFFF_FFFF, 6));
		send_event(mk(OP_INPUT, 0, 32'hFFFF_FFFF, 6));
		send_event(mk(OP_AUTH, 1, 0, 7));
		send_event(mk(OP_LOCAL, 1, 0, 7));
		send_event(mk(OP_INPUT, 1, 3, 7));
		send_event(mk(OP_START, 0, 0, 100));
		send_event(mk(OP_START, 0, 0, 100));
		send_event(mk(OP_PROGRESS, 0, 0, 50));
		send_event(mk(OP_PROGRESS, 1, 4, 1099));
		send_event(mk(OP_POLL, 0, 0, 2100));
		send_event(mk(OP_CANCEL, 0, 0, 2200));
		drain();
	endtask

	task automatic test_random();
		// The group runs once; afterward the block refuses rank events, and the
		// random part exercises those paths with both timeouts set to their maximum.
		write_reg(REG_NOPROG, 32'hFFFF_FFFF);
		write_reg(REG_HARD, 32'hFFFF_FFFF);
		for (int i = 0; i < 1400; i++) begin
			send_event(noise());
			if (i == 700) drain();
		end
		drain();
	endtask

	task automatic test_registers();
		write_reg(REG_EPOCH, 64'hFFFF_FFFF);
		write_reg(REG_DIGEST, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_RANKS, 5'd31);
		write_reg(REG_NOPROG, 1);
		write_reg(REG_HARD, 1);
		for (int i = 0; i < 20; i++) send_event(noise());
		drain();
		write_reg(REG_DIGEST, 0);
		write_reg(REG_RANKS, 0);
		write_reg(REG_EPOCH, 1);
		for (int i = 0; i < 20; i++) send_event(noise());
		drain();
	endtask

	// result checker
	initial begin
		verdict_t want, got;
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(0, 9) < 6) ? 1'b1 : 1'b0;
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (pending_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected word %h", got);
				end else begin
					want = pending_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected ok=%0d err=%0d st=%0d t=%0d, got ok=%0d err=%0d st=%0d t=%0d",
								want.ok, want.err, want.state, want.term_time,
								got.ok, got.err, got.state, got.term_time);
					end
				end
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("tb_collective_barrier_watchdog failed");
				$finish;
			end
		end
	end

	initial begin
		clear_model();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		test_directed();
		test_registers();
		test_random();
		drain();
		if (mismatches == 0 && pending_q.size() == 0) begin
			$display("tb_collective_barrier_watchdog passed");
		end else begin
			$display("tb_collective_barrier_watchdog failed");
		end
		$finish;
	end

endmodule

>>> collective_barrier_watchdog.f
hw/rtl/cbw_pkg.sv
hw/rtl/cbw_scan.sv
hw/rtl/collective_barrier_watchdog.sv
bench/tb_collective_barrier_watchdog.sv
